// File: rtl/core/brr_pkg.sv
`default_nettype none

package brr_pkg;

  localparam int MAX_ROW_LEN = 64;
  localparam int VAL_W       = 64;
  localparam int RLEN_W      = 7;
  localparam int FILL_W      = $clog2(MAX_ROW_LEN);
  localparam int CNT_W       = $clog2(MAX_ROW_LEN + 1);

  typedef logic [VAL_W-1:0] value_t;

  // Shift command broadcast to every cell of the row chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_op_t;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/brr_cell.sv
`default_nettype none

module brr_cell
  import brr_pkg::*;
(
  input  wire logic      clk,
  input  wire shift_op_t op,
  input  wire value_t    left_in,
  input  wire value_t    right_in,
  output value_t         data_q
);

  value_t data_r;

  // Push takes the neighbor toward the head, pop takes the one toward the tail
  always_ff @(posedge clk) begin
    if (op.push) begin
      data_r <= left_in;
    end else if (op.pop) begin
      data_r <= right_in;
    end
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

// File: rtl/core/brr_chain.sv
`default_nettype none

module brr_chain
  import brr_pkg::*;
(
  input  wire logic      clk,
  input  wire shift_op_t op,
  input  wire value_t    push_value,
  output value_t         head_value
);

  value_t cell_q [MAX_ROW_LEN];

  for (genvar i = 0; i < MAX_ROW_LEN; i++) begin : g_cell
    value_t left_w;
    value_t right_w;

    if (i == 0) begin : g_head
      assign left_w = push_value;
    end else begin : g_body_l
      assign left_w = cell_q[i-1];
    end

    // Tail refills with its own word on pop; that slot is never read again
    if (i == MAX_ROW_LEN - 1) begin : g_tail
      assign right_w = cell_q[i];
    end else begin : g_body_r
      assign right_w = cell_q[i+1];
    end

    brr_cell u_cell (
      .clk      (clk),
      .op       (op),
      .left_in  (left_w),
      .right_in (right_w),
      .data_q   (cell_q[i])
    );
  end

  assign head_value = cell_q[0];

endmodule

`default_nettype wire

// File: rtl/core/boustrophedon_row_reorder_core.sv
`default_nettype none

// Serpentine row reorder. Grid values enter one per transfer in arrival order
// and are split into rows, either every cfg row_length points or, when
// row_length is 0, at the in_end_of_row mark. Even rows (0, 2, ...) leave
// unchanged; each odd row is collected and leaves reversed once it ends, so
// the same core turns serpentine order into plain order and back.
// in_first_of_field restarts at even row 0 and drops any partly collected
// row. A row that reaches MAX_ROW_LEN (64) points without ending is closed
// there and its last result carries out_row_overflow. Even-row points pass
// to the output register and odd-row points are pushed into the chain; when
// an odd row ends, the core drains it as out_ready allows and takes no input
// meanwhile. Storage for the odd row is a chain of 64 cells that shift toward
// the tail on each collected point and toward the head on each emitted point,
// so the head cell always holds the next result. A single output register
// holds results; input keeps flowing while it is being taken. Write
// row_length only while the core is idle.
module boustrophedon_row_reorder_core
  import brr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [RLEN_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire value_t            in_value,
  input  wire logic              in_end_of_row,
  input  wire logic              in_first_of_field,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output value_t                 out_value,
  output logic                   out_last_of_row,
  output logic                   out_row_overflow
);

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              odd_r, odd_nxt;
  logic [CNT_W-1:0]  drain_cnt_r, drain_cnt_nxt;
  logic              drain_ovf_r, drain_ovf_nxt;
  logic [RLEN_W-1:0] row_length_r;

  logic              out_valid_r, out_valid_nxt;
  value_t            out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  shift_op_t         shift_op;
  value_t            head_value;

  logic              out_free;
  logic              in_xfer;
  logic [FILL_W-1:0] fill_eff;
  logic              odd_eff;
  logic [CNT_W-1:0]  pos_n;
  logic              row_ends;
  logic              row_ovf;
  logic              row_done;
  logic              drain_last;

  // Odd-row storage
  brr_chain u_chain (
    .clk        (clk),
    .op         (shift_op),
    .push_value (in_value),
    .head_value (head_value)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Row position of the incoming point; a new field restarts at even row 0
  assign fill_eff = in_first_of_field ? '0 : fill_r;
  assign odd_eff  = in_first_of_field ? 1'b0 : odd_r;
  assign pos_n    = CNT_W'(fill_eff) + CNT_W'(1);

  // Fixed length takes precedence; the in-band mark counts only in mark mode
  assign row_ends = (row_length_r == '0) ? in_end_of_row
                                         : (CNT_W'(row_length_r) == pos_n);
  assign row_ovf  = !row_ends && (pos_n >= CNT_W'(MAX_ROW_LEN));
  assign row_done = row_ends || row_ovf;

  assign drain_last = (drain_cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    odd_nxt       = odd_r;
    drain_cnt_nxt = drain_cnt_r;
    drain_ovf_nxt = drain_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    shift_op      = '0;
    in_ready      = 1'b0;

    case (state_r)
      ST_RUN: begin
        in_ready = out_free;
        if (in_xfer) begin
          if (!odd_eff) begin
            // Even row: pass straight to the output register
            out_valid_nxt = 1'b1;
            out_value_nxt = in_value;
            out_last_nxt  = row_done;
            out_ovf_nxt   = row_ovf;
            fill_nxt      = row_done ? '0 : pos_n[FILL_W-1:0];
            odd_nxt       = row_done;
          end else begin
            // Odd row: collect into the chain, reverse out at row end
            shift_op.push = 1'b1;
            if (row_done) begin
              fill_nxt      = '0;
              odd_nxt       = 1'b0;
              drain_cnt_nxt = pos_n;
              drain_ovf_nxt = row_ovf;
              state_nxt     = ST_DRAIN;
            end else begin
              fill_nxt = pos_n[FILL_W-1:0];
              odd_nxt  = 1'b1;
            end
          end
        end
      end
      ST_DRAIN: begin
        // Head cell holds the most recent point; pop one per free slot
        if (out_free) begin
          shift_op.pop  = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = head_value;
          out_last_nxt  = drain_last;
          out_ovf_nxt   = drain_last && drain_ovf_r;
          drain_cnt_nxt = drain_cnt_r - CNT_W'(1);
          if (drain_last) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      fill_r       <= '0;
      odd_r        <= 1'b0;
      drain_cnt_r  <= '0;
      drain_ovf_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      row_length_r <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      odd_r       <= odd_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      drain_ovf_r <= drain_ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        row_length_r <= cfg_wr_data;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_last_of_row  = out_last_r;
  assign out_row_overflow = out_ovf_r;

`ifndef SYNTH
  // No input is taken while an odd row drains
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> !in_ready)
    else $error("input taken during drain");

  // A drain always has points left to emit
  a_drain_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (drain_cnt_r != '0))
    else $error("drain with empty count");

  // Overflow is flagged only on a row's last result
  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_overflow) |-> out_last_of_row)
    else $error("overflow flag off row end");

  // Ending an odd row starts a drain of that row
  a_odd_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && odd_eff && row_done) |=> (state_r == ST_DRAIN))
    else $error("odd row end did not start drain");
`endif

endmodule

`default_nettype wire
